@@ rtl/core/icmpc_pkg.sv @@
// Shared types and constants for the ICMP header checker core.
// No dependencies; imported by the front, queue, back and top modules.
`timescale 1ns / 1ps

package icmpc_pkg;

    localparam logic [7:0]  ICMP_PROTO      = 8'd1;
    localparam logic [15:0] HDR_LEN         = 16'd8;
    localparam logic [15:0] EXTRA_QUOTE     = 16'd28;
    localparam logic [15:0] TIMESTAMP_LEN   = 16'd20;
    localparam logic [15:0] SUM_GOOD        = 16'hFFFF;
    localparam int          QUEUE_DEPTH     = 2;

    // ICMP types with length rules
    localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] TYPE_SOURCE_QUENCH = 8'd4;
    localparam logic [7:0] TYPE_REDIRECT      = 8'd5;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] TYPE_PARAM_PROBLEM = 8'd12;
    localparam logic [7:0] TYPE_TSTAMP        = 8'd13;
    localparam logic [7:0] TYPE_TSTAMP_REPLY  = 8'd14;
    localparam logic [7:0] TYPE_INFO_REQ      = 8'd15;
    localparam logic [7:0] TYPE_INFO_REPLY    = 8'd16;

    // register select bit (byte address bit 2)
    localparam logic REG_HAS_ERROR_PORT = 1'b0;
    localparam logic REG_COUNT_DETAILS  = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_PASS         = 2'd0,
        VERDICT_NOT_ICMP     = 2'd1,
        VERDICT_BAD_LENGTH   = 2'd2,
        VERDICT_BAD_CHECKSUM = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ROUTE_FORWARD = 2'd0,
        ROUTE_ERROR   = 2'd1,
        ROUTE_DISCARD = 2'd2
    } route_t;

    // one finished packet, handed from front to back
    typedef struct packed {
        logic        proto_ok;
        logic [7:0]  msg_type;
        logic [15:0] length;
        logic [15:0] sum;
    } icmpc_rec_t;

    typedef struct packed {
        logic has_error_port;
        logic count_details;
    } icmpc_cfg_t;

endpackage

@@ rtl/core/icmpc_front.sv @@
// Front end: takes packet bytes, keeps count, type and ones'-complement sum,
// and pushes one record per packet into the queue. Depends on icmpc_pkg.
`timescale 1ns / 1ps

module icmpc_front
    import icmpc_pkg::*;
#(
    parameter int MAX_LENGTH = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [7:0]  ip_protocol,
    input  logic        header_present,
    output logic        push,
    output icmpc_rec_t  push_rec,
    input  logic        queue_full
);

    localparam logic [15:0] LEN_CAP = 16'(MAX_LENGTH);

    logic [15:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  held_reg, held_next;
    logic        odd_reg, odd_next;
    logic [7:0]  type_reg, type_next;
    logic        proto_ok_reg, proto_ok_next;

    logic [15:0] count_base, sum_base, len_cur, word, sum_add, sum_cur;
    logic [7:0]  held_base;
    logic        odd_base;
    logic [16:0] sum_wide;
    logic        fire;

    assign in_stall = queue_full;
    assign fire     = in_valid && !in_stall;

    always_comb
    begin
        // a first mark restarts the packet state
        count_base    = first_byte ? 16'd0 : count_reg;
        sum_base      = first_byte ? 16'd0 : sum_reg;
        held_base     = first_byte ? 8'd0  : held_reg;
        odd_base      = first_byte ? 1'b0  : odd_reg;
        proto_ok_next = first_byte ? (header_present && ip_protocol == ICMP_PROTO)
                                   : proto_ok_reg;
        type_next     = (count_base == 16'd0) ? data_byte : type_reg;
        len_cur       = (count_base < LEN_CAP) ? count_base + 16'd1 : count_base;

        // low byte of a pair, or an odd last byte padded with zero
        word     = odd_base ? {held_base, data_byte} : {data_byte, 8'h00};
        sum_wide = {1'b0, sum_base} + {1'b0, word};
        sum_add  = sum_wide[15:0] + {15'd0, sum_wide[16]};
        sum_cur  = (odd_base || last_byte) ? sum_add : sum_base;

        if (last_byte)
        begin
            count_next = 16'd0;
            sum_next   = 16'd0;
            held_next  = 8'd0;
            odd_next   = 1'b0;
        end
        else
        begin
            count_next = len_cur;
            sum_next   = sum_cur;
            held_next  = odd_base ? held_base : data_byte;
            odd_next   = !odd_base;
        end
    end

    assign push              = fire && last_byte;
    assign push_rec.proto_ok = proto_ok_next;
    assign push_rec.msg_type = type_next;
    assign push_rec.length   = len_cur;
    assign push_rec.sum      = sum_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 16'd0;
            sum_reg      <= 16'd0;
            held_reg     <= 8'd0;
            odd_reg      <= 1'b0;
            type_reg     <= 8'd0;
            proto_ok_reg <= 1'b0;
        end
        else if (fire)
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            held_reg     <= held_next;
            odd_reg      <= odd_next;
            type_reg     <= type_next;
            proto_ok_reg <= proto_ok_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |=> (count_reg == 16'd0 && !odd_reg && sum_reg == 16'd0))
        else $error("packet state not cleared after last beat");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_CAP)
        else $error("byte count above cap");

endmodule

@@ rtl/core/icmpc_queue.sv @@
// Short record queue between front and back ends.
// Depends on icmpc_pkg for the record type and depth.
`timescale 1ns / 1ps

module icmpc_queue
    import icmpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  icmpc_rec_t wdata,
    output logic       full,
    input  logic       pop,
    output icmpc_rec_t rdata,
    output logic       empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    icmpc_rec_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full  = (fill_reg == CNT_FULL);
    assign empty = (fill_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_FULL)
        else $error("queue fill count out of range");

endmodule

@@ rtl/core/icmpc_back.sv @@
// Back end: judges queued packet records, updates drop counters and holds
// the result beat. Depends on icmpc_pkg.
`timescale 1ns / 1ps

module icmpc_back
    import icmpc_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  icmpc_cfg_t  cfg,
    input  icmpc_rec_t  head,
    input  logic        queue_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [1:0]  route,
    output logic [15:0] message_length,
    output logic [31:0] total_drops,
    output logic [31:0] not_icmp_drops,
    output logic [31:0] bad_length_drops,
    output logic [31:0] bad_checksum_drops
);

    logic                    valid_reg;
    verdict_t                verdict_reg, verdict_next;
    route_t                  route_reg, route_next;
    logic [15:0]             length_reg;
    logic [COUNTER_BITS-1:0] total_reg, not_icmp_reg, bad_length_reg, bad_checksum_reg;
    logic                    len_bad;
    logic [63:0]             total_ext, not_icmp_ext, bad_length_ext, bad_checksum_ext;

    always_comb
    begin
        len_bad = 1'b0;
        case (head.msg_type) inside
            TYPE_DEST_UNREACH, TYPE_SOURCE_QUENCH, TYPE_REDIRECT,
            TYPE_TIME_EXCEEDED, TYPE_PARAM_PROBLEM:
                len_bad = head.length < (HDR_LEN + EXTRA_QUOTE);
            TYPE_TSTAMP, TYPE_TSTAMP_REPLY:
                len_bad = head.length != TIMESTAMP_LEN;
            TYPE_INFO_REQ, TYPE_INFO_REPLY:
                len_bad = head.length != HDR_LEN;
            default:
                len_bad = 1'b0;
        endcase
        if (head.length < HDR_LEN)
        begin
            len_bad = 1'b1;
        end

        if (!head.proto_ok)
            verdict_next = VERDICT_NOT_ICMP;
        else if (len_bad)
            verdict_next = VERDICT_BAD_LENGTH;
        else if (head.sum != SUM_GOOD)
            verdict_next = VERDICT_BAD_CHECKSUM;
        else
            verdict_next = VERDICT_PASS;

        if (verdict_next == VERDICT_PASS)
            route_next = ROUTE_FORWARD;
        else if (cfg.has_error_port)
            route_next = ROUTE_ERROR;
        else
            route_next = ROUTE_DISCARD;
    end

    // load a new result when the output slot is free or being taken
    assign pop = !queue_empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            total_reg        <= '0;
            not_icmp_reg     <= '0;
            bad_length_reg   <= '0;
            bad_checksum_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end

            if (pop && verdict_next != VERDICT_PASS)
            begin
                total_reg <= total_reg + 1'b1;
                if (cfg.count_details)
                begin
                    case (verdict_next)
                        VERDICT_NOT_ICMP:     not_icmp_reg     <= not_icmp_reg + 1'b1;
                        VERDICT_BAD_LENGTH:   bad_length_reg   <= bad_length_reg + 1'b1;
                        VERDICT_BAD_CHECKSUM: bad_checksum_reg <= bad_checksum_reg + 1'b1;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict_reg <= verdict_next;
            route_reg   <= route_next;
            length_reg  <= head.length;
        end
    end

    assign total_ext        = 64'(total_reg);
    assign not_icmp_ext     = 64'(not_icmp_reg);
    assign bad_length_ext   = 64'(bad_length_reg);
    assign bad_checksum_ext = 64'(bad_checksum_reg);

    assign out_valid          = valid_reg;
    assign verdict            = verdict_reg;
    assign route              = route_reg;
    assign message_length     = length_reg;
    assign total_drops        = total_ext[31:0];
    assign not_icmp_drops     = not_icmp_ext[31:0];
    assign bad_length_drops   = bad_length_ext[31:0];
    assign bad_checksum_drops = bad_checksum_ext[31:0];

    a_pass_forwards: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && verdict_reg == VERDICT_PASS) |-> route_reg == ROUTE_FORWARD)
        else $error("passing packet not forwarded");

    a_fail_not_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && verdict_reg != VERDICT_PASS) |-> route_reg != ROUTE_FORWARD)
        else $error("failed packet forwarded");

    a_total_counts_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && verdict_next != VERDICT_PASS) |=> total_reg == $past(total_reg) + 1'b1)
        else $error("total drop counter missed a failure");

endmodule

@@ rtl/core/icmp_header_checker_core.sv @@
// ICMP header checker top level: APB register file, front end, record queue
// and back end. Depends on icmpc_pkg, icmpc_front, icmpc_queue, icmpc_back.
//
//   channel | signals                          | direction
//   --------+----------------------------------+-----------------------
//   in      | in_valid / in_stall, byte fields | packet bytes, one a beat
//   out     | out_valid / out_stall, results   | one verdict per packet
//   cfg     | psel/penable/pwrite/paddr/pwdata | register writes and reads
//
// One byte beat is taken every cycle while in_stall is low; the running
// sum is one 16-bit add with end-around carry per byte pair (or odd last
// byte) in the front end. After its last byte is taken, a packet's record
// is written into the queue and then loaded into the back-end output register.
// The two-entry queue lets the front keep taking bytes while a result waits;
// in_stall rises only when the queue is full. Reset clears all packet state,
// counters and both registers; no clearing pass is needed.
`timescale 1ns / 1ps

module icmp_header_checker_core
    import icmpc_pkg::*;
#(
    parameter int MAX_LENGTH   = 65535,
    parameter int COUNTER_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [7:0]  ip_protocol,
    input  logic        header_present,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [1:0]  route,
    output logic [15:0] message_length,
    output logic [31:0] total_drops,
    output logic [31:0] not_icmp_drops,
    output logic [31:0] bad_length_drops,
    output logic [31:0] bad_checksum_drops
);

    icmpc_cfg_t cfg_reg;
    logic       cfg_write;
    logic       push, pop, queue_full, queue_empty;
    icmpc_rec_t push_rec, head_rec;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_HAS_ERROR_PORT: cfg_reg.has_error_port <= pwdata[0];
                REG_COUNT_DETAILS:  cfg_reg.count_details  <= pwdata[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HAS_ERROR_PORT: prdata = {31'd0, cfg_reg.has_error_port};
            REG_COUNT_DETAILS:  prdata = {31'd0, cfg_reg.count_details};
            default:            prdata = 32'd0;
        endcase
    end

    icmpc_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .ip_protocol    (ip_protocol),
        .header_present (header_present),
        .push           (push),
        .push_rec       (push_rec),
        .queue_full     (queue_full)
    );

    icmpc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_rec),
        .full  (queue_full),
        .pop   (pop),
        .rdata (head_rec),
        .empty (queue_empty)
    );

    icmpc_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .head               (head_rec),
        .queue_empty        (queue_empty),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .verdict            (verdict),
        .route              (route),
        .message_length     (message_length),
        .total_drops        (total_drops),
        .not_icmp_drops     (not_icmp_drops),
        .bad_length_drops   (bad_length_drops),
        .bad_checksum_drops (bad_checksum_drops)
    );

endmodule
